>>> hw/rtl/hscu_pkg.sv
// Package: payload structs, item kinds, status codes and sizes of the critical/uncovered engine.
package hscu_pkg;

  localparam int unsigned MaxVertices = 32;
  localparam int unsigned MaxEdges    = 64;
  localparam int unsigned MaxLevels   = 32;
  localparam int unsigned VtxW        = 5;
  localparam int unsigned LvlW        = 5;
  localparam int unsigned OvlAddrW    = 10;

  typedef enum logic [2:0] {
    KindLoad   = 3'd0,
    KindClear  = 3'd1,
    KindCheck  = 3'd2,
    KindAdd    = 3'd3,
    KindRemove = 3'd4
  } kind_e;

  // Marks the power-up sweep, which gives no result
  localparam logic [2:0] KindNone = 3'd7;

  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatBadPre  = 2'd1,
    StatBadVtx  = 2'd2
  } status_e;

  localparam logic CfgNumEdges    = 1'b0;
  localparam logic CfgNumVertices = 1'b1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  vertex;
    logic [31:0] vertex_set;
    logic [4:0]  level;
    logic [63:0] edge_mask;
  } in_item_t;

  typedef struct packed {
    logic        violates;
    logic [1:0]  status;
    logic [63:0] uncovered_edges;
    logic [63:0] vertex_critical_edges;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle,
    StClrCrit,
    StClrOvl,
    StRdV,
    StDecide,
    StRdW,
    StModW,
    StFinal,
    StOut
  } state_e;

endpackage

>>> hw/rtl/hscu_ram.sv
// Generic single-port synchronous RAM with registered read.
module hscu_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

>>> hw/rtl/hitting_set_crit_uncov_engine.sv
// Top level: critical/uncovered edge engine for minimal hitting set search.
// One item is taken at a time and gives one result beat. Load, out-of-range
// and bad-kind items go straight to the final read and the output register;
// a broken precondition is found after the vertex's critical word and row are
// read. Check, add and remove read the vertex's critical word and then walk all
// 32 vertex slots, a read and then a modify/write step per member of vertex_set
// and a single step per other slot, over the single-port critical-set and
// overlay memories. Clear sweeps all 32 critical words. The next item is
// accepted only after the result is taken. After reset a clearing pass zeroes
// all 1024 overlay words and then all 32 critical-set words; no item is taken
// until it ends (config writes are taken). The incidence row memory is not
// cleared: reading a never-loaded row is outside the contract. The output
// register holds a result until it is taken.
module hitting_set_crit_uncov_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hscu_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hscu_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [6:0]          cfg_data_i
);

  hscu_pkg::state_e state_q, state_d;
  hscu_pkg::in_item_t item_q, item_d;
  logic [6:0]  ne_q;
  logic [5:0]  nv_q;
  logic [63:0] unc_q, unc_d;
  logic [63:0] vcrit_q, vcrit_d;   // crit[v] as read
  logic [63:0] row_q, row_d;       // row(v) & emask
  logic        viol_q, viol_d;
  logic [1:0]  stat_q, stat_d;
  logic [10:0] cnt_q, cnt_d;       // sweep / walk counter
  logic        ovl_rd_q, ovl_rd_d; // cleared on each accepted item, otherwise unused
  hscu_pkg::out_item_t out_q, out_d;
  logic        ov_q, ov_d;

  // memories
  logic        crit_we, row_we, ovl_we;
  logic [4:0]  crit_a, row_a;
  logic [9:0]  ovl_a;
  logic [63:0] crit_wd, ovl_wd, crit_rd, row_rd, ovl_rd;

  hscu_ram #(.Width(64), .Depth(32))   u_crit (.clk_i, .we_i(crit_we), .addr_i(crit_a),
    .wdata_i(crit_wd), .rdata_o(crit_rd));
  hscu_ram #(.Width(64), .Depth(32))   u_row  (.clk_i, .we_i(row_we), .addr_i(row_a),
    .wdata_i(in_data_i.edge_mask), .rdata_o(row_rd));
  hscu_ram #(.Width(64), .Depth(1024)) u_ovl  (.clk_i, .we_i(ovl_we), .addr_i(ovl_a),
    .wdata_i(ovl_wd), .rdata_o(ovl_rd));

  logic [63:0] emask;
  logic [5:0]  lim;
  logic [31:0] smask, s_eff;
  logic [4:0]  w;
  logic        w_in;

  always_comb begin
    logic [6:0] n;
    n = (ne_q > 7'd64) ? 7'd64 : ne_q;
    emask = (n == 7'd64) ? '1 : ((64'd1 << n[5:0]) - 64'd1);
    lim = (nv_q > 6'd32) ? 6'd32 : nv_q;
    smask = (lim == 6'd32) ? '1 : ((32'd1 << lim[4:0]) - 32'd1);
  end

  assign s_eff = item_q.vertex_set & smask;
  assign w     = cnt_q[4:0];
  assign w_in  = s_eff[w] && ({1'b0, w} < lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hscu_pkg::StClrOvl;
      ne_q    <= 7'd64;
      nv_q    <= 6'd32;
      unc_q   <= '1;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      ovl_rd_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unc_q   <= unc_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      ovl_rd_q <= ovl_rd_d;
      if (cfg_we_i) begin
        if (cfg_index_i == hscu_pkg::CfgNumEdges) ne_q <= cfg_data_i;
        else nv_q <= cfg_data_i[5:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    vcrit_q <= vcrit_d;
    row_q   <= row_d;
    viol_q  <= viol_d;
    stat_q  <= stat_d;
    out_q   <= out_d;
  end

  always_comb begin
    logic v_in_s, in_rng;
    state_d = state_q; item_d = item_q; unc_d = unc_q; vcrit_d = vcrit_q;
    row_d = row_q; viol_d = viol_q; stat_d = stat_q; cnt_d = cnt_q;
    out_d = out_q; ov_d = ov_q; ovl_rd_d = ovl_rd_q;
    crit_we = 1'b0; crit_a = w; crit_wd = '0;
    row_we = 1'b0; row_a = item_q.vertex;
    ovl_we = 1'b0; ovl_a = {item_q.level, w}; ovl_wd = '0;
    in_stall_o = 1'b1;
    v_in_s = s_eff[item_q.vertex];
    in_rng = {1'b0, item_q.vertex} < lim;
    if (ov_q && !out_stall_i) ov_d = 1'b0;

    case (state_q)
      hscu_pkg::StClrOvl: begin
        ovl_we = 1'b1; ovl_a = cnt_q[9:0];
        cnt_d = cnt_q + 11'd1;
        if (cnt_q == 11'd1023) begin
          cnt_d = '0; state_d = hscu_pkg::StClrCrit; stat_d = hscu_pkg::StatOk;
          item_d.kind = hscu_pkg::KindNone; // reset sweep: no result
        end
      end
      hscu_pkg::StClrCrit: begin
        crit_we = 1'b1;
        cnt_d = cnt_q + 11'd1;
        if (cnt_q == 11'd31) begin
          cnt_d = '0;
          if (item_q.kind == hscu_pkg::KindClear) state_d = hscu_pkg::StFinal;
          else state_d = hscu_pkg::StIdle;
        end
      end
      hscu_pkg::StIdle: begin
        in_stall_o = ov_q;
        crit_a = in_data_i.vertex;
        row_a  = in_data_i.vertex;
        if (in_valid_i && !ov_q) begin
          item_d = in_data_i; viol_d = 1'b0; stat_d = hscu_pkg::StatOk; cnt_d = '0;
          ovl_rd_d = 1'b0;
          if (in_data_i.kind == hscu_pkg::KindClear) begin
            unc_d = emask; state_d = hscu_pkg::StClrCrit;
          end else if (in_data_i.kind > hscu_pkg::KindRemove) begin
            stat_d = hscu_pkg::StatBadPre; state_d = hscu_pkg::StFinal;
          end else if ({1'b0, in_data_i.vertex} >= lim) begin
            stat_d = hscu_pkg::StatBadVtx; state_d = hscu_pkg::StFinal;
          end else if (in_data_i.kind == hscu_pkg::KindLoad) begin
            row_we = 1'b1; state_d = hscu_pkg::StFinal;
          end else state_d = hscu_pkg::StRdV;
        end
      end
      hscu_pkg::StRdV: begin
        // read data for crit[v] and row(v) arrives now
        vcrit_d = crit_rd; row_d = row_rd & emask;
        state_d = hscu_pkg::StDecide;
      end
      hscu_pkg::StDecide: begin
        state_d = hscu_pkg::StRdW;
        if (v_in_s) begin
          stat_d = hscu_pkg::StatBadPre; state_d = hscu_pkg::StFinal;
        end else if (item_q.kind == hscu_pkg::KindRemove) begin
          if ((unc_q & vcrit_q) != '0) begin
            stat_d = hscu_pkg::StatBadPre; state_d = hscu_pkg::StFinal;
          end else begin
            unc_d = unc_q | vcrit_q;
            crit_we = 1'b1; crit_a = item_q.vertex; crit_wd = '0;
          end
        end else if (vcrit_q != '0) begin
          stat_d = hscu_pkg::StatBadPre; state_d = hscu_pkg::StFinal;
        end else if (item_q.kind == hscu_pkg::KindAdd) begin
          unc_d = unc_q & ~row_q;
          crit_we = 1'b1; crit_a = item_q.vertex; crit_wd = row_q & unc_q;
        end else begin
          row_d = row_q & ~unc_q; // check test set
        end
      end
      hscu_pkg::StRdW: begin
        // issue reads for w (crit and overlay on their own ports)
        if (cnt_q[5]) begin
          crit_a = item_q.vertex; state_d = hscu_pkg::StFinal;
        end else if (!w_in) begin
          if (item_q.kind == hscu_pkg::KindAdd) ovl_we = 1'b1;
          cnt_d = cnt_q + 11'd1;
        end else state_d = hscu_pkg::StModW;
      end
      hscu_pkg::StModW: begin
        if (item_q.kind == hscu_pkg::KindCheck) begin
          if ((crit_rd & ~row_q) == '0) viol_d = 1'b1;
          cnt_d = cnt_q + 11'd1; state_d = hscu_pkg::StRdW;
        end else if (item_q.kind == hscu_pkg::KindAdd) begin
          crit_we = 1'b1; crit_wd = crit_rd & ~row_q;
          ovl_we = 1'b1; ovl_wd = crit_rd & row_q;
          cnt_d = cnt_q + 11'd1; state_d = hscu_pkg::StRdW;
        end else begin
          crit_we = 1'b1; crit_wd = crit_rd | ovl_rd;
          cnt_d = cnt_q + 11'd1; state_d = hscu_pkg::StRdW;
        end
      end
      hscu_pkg::StFinal: begin
        crit_a = item_q.vertex; // read issued; data next cycle
        state_d = hscu_pkg::StOut;
      end
      hscu_pkg::StOut: begin
        out_d.violates = viol_q;
        out_d.status = stat_q;
        out_d.uncovered_edges = unc_q;
        out_d.vertex_critical_edges = in_rng ? crit_rd : '0;
        ov_d = 1'b1;
        state_d = hscu_pkg::StIdle;
      end
      default: state_d = hscu_pkg::StIdle;
    endcase
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  // A new item is never taken while a result is still held.
  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> in_stall_o) else $error("item accepted over held result");
  // A held result does not change while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> (ov_q && $stable(out_q))) else $error("result lost");
  // A violation is only reported by a check that passed its preconditions.
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_q.violates) |-> out_q.status == hscu_pkg::StatOk)
    else $error("bad status");
endmodule

>>> dv/hitting_set_crit_uncov_engine_tb.sv
// Testbench for the critical/uncovered edge engine: directed table plus random search walks.
`timescale 1ns / 1ps

module hitting_set_crit_uncov_engine_tb;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  hscu_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  hscu_pkg::out_item_t out_data_o;
  logic                cfg_we_i = 1'b0;
  logic                cfg_index_i = 1'b0;
  logic [6:0]          cfg_data_i = '0;

  hitting_set_crit_uncov_engine uut (.*);

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow state of the engine
  logic [63:0] row_mem [hscu_pkg::MaxVertices];
  logic [63:0] crit_mem [hscu_pkg::MaxVertices];
  logic [63:0] uncov_set;
  logic [63:0] ovl_mem [hscu_pkg::MaxLevels*hscu_pkg::MaxVertices];
  logic [6:0]  edge_cnt;
  logic [5:0]  vtx_cnt;
  bit          row_loaded [hscu_pkg::MaxVertices];

  hscu_pkg::out_item_t expected_q [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned violations_seen = 0;
  bit          in_idle_en = 1'b1;
  bit          out_idle_en = 1'b1;
  bit          hold_rx = 1'b0;

  function automatic logic [63:0] edge_ones();
    int unsigned n;
    n = (edge_cnt > hscu_pkg::MaxEdges) ? hscu_pkg::MaxEdges : edge_cnt;
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic int unsigned vtx_limit();
    return (vtx_cnt > hscu_pkg::MaxVertices) ? hscu_pkg::MaxVertices : vtx_cnt;
  endfunction

  // Advance the shadow state by one beat and return what the engine should send
  function automatic hscu_pkg::out_item_t apply_item(hscu_pkg::in_item_t it);
    hscu_pkg::out_item_t r;
    int unsigned lim;
    logic [31:0] s;
    logic [63:0] em, row, tst;
    logic        in_rng;
    int unsigned v;
    lim = vtx_limit();
    s = (lim >= 32) ? it.vertex_set : (it.vertex_set & ((32'd1 << lim) - 1));
    em = edge_ones();
    v = it.vertex;
    in_rng = v < lim;
    r = '0;
    r.status = hscu_pkg::StatOk;
    if (it.kind == hscu_pkg::KindClear) begin
      foreach (crit_mem[i]) crit_mem[i] = '0;
      uncov_set = em;
    end else if (it.kind > hscu_pkg::KindRemove) begin
      r.status = hscu_pkg::StatBadPre;
    end else if (!in_rng) begin
      r.status = hscu_pkg::StatBadVtx;
    end else if (it.kind == hscu_pkg::KindLoad) begin
      row_mem[v] = it.edge_mask;
    end else begin
      row = row_mem[v] & em;
      if (s[v]) begin
        r.status = hscu_pkg::StatBadPre;
      end else if (it.kind == hscu_pkg::KindRemove) begin
        if ((uncov_set & crit_mem[v]) != 0 || it.level >= hscu_pkg::MaxLevels) begin
          r.status = hscu_pkg::StatBadPre;
        end else begin
          uncov_set |= crit_mem[v];
          crit_mem[v] = '0;
          for (int w = 0; w < lim; w++)
            if (s[w]) crit_mem[w] |= ovl_mem[it.level*hscu_pkg::MaxVertices + w];
        end
      end else if (crit_mem[v] != 0) begin
        r.status = hscu_pkg::StatBadPre;
      end else if (it.kind == hscu_pkg::KindCheck) begin
        tst = row & ~uncov_set;
        for (int w = 0; w < lim; w++)
          if (s[w] && (crit_mem[w] & ~tst) == 0) r.violates = 1'b1;
      end else begin
        crit_mem[v] = row & uncov_set;
        uncov_set &= ~row;
        for (int w = 0; w < hscu_pkg::MaxVertices; w++) begin
          if (w < lim && s[w]) begin
            ovl_mem[it.level*hscu_pkg::MaxVertices + w] = crit_mem[w] & row;
            crit_mem[w] &= ~row;
          end else begin
            ovl_mem[it.level*hscu_pkg::MaxVertices + w] = '0;
          end
        end
      end
    end
    r.uncovered_edges = uncov_set;
    r.vertex_critical_edges = in_rng ? crit_mem[v] : '0;
    return r;
  endfunction

  // Send one beat; hold valid and payload until taken, leave valid up afterwards
  task automatic send_beat(hscu_pkg::in_item_t it);
    int unsigned gap;
    if (in_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(apply_item(it));
    @(negedge clk_i);
  endtask

  // Drive a beat and check a typed-in result against the predictor as well
  task automatic send_known(hscu_pkg::in_item_t it, logic [1:0] st, logic [63:0] unc);
    hscu_pkg::out_item_t p;
    p = apply_item(it);
    if (p.status != st || p.uncovered_edges != unc) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row kind %0d: exp s%0d u%h got s%0d u%h", it.kind, st, unc,
                 p.status, p.uncovered_edges);
    end
    expected_q.push_back(p);
    in_data_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == hscu_pkg::CfgNumEdges) edge_cnt = val;
    else vtx_cnt = {1'b0, val[4:0]} | (val[5] ? 6'd32 : 6'd0);
  endtask

  function automatic hscu_pkg::in_item_t mk(hscu_pkg::kind_e k, int unsigned v,
                                            logic [31:0] s, int unsigned lv,
                                            logic [63:0] m);
    hscu_pkg::in_item_t it;
    it.kind = k;
    it.vertex = 5'(v);
    it.vertex_set = s;
    it.level = 5'(lv);
    it.edge_mask = m;
    return it;
  endfunction

  // Receiver: random stall bursts, or a long hold when asked
  always begin
    @(negedge clk_i);
    if (hold_rx) begin
      out_stall_i <= 1'b1;
    end else if (out_idle_en && $urandom_range(0, 6) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    hscu_pkg::out_item_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_data_o);
      end else begin
        e = expected_q.pop_front();
        if (e.violates) violations_seen++;
        if (out_data_o.violates !== e.violates || out_data_o.status !== e.status ||
            out_data_o.uncovered_edges !== e.uncovered_edges ||
            out_data_o.vertex_critical_edges !== e.vertex_critical_edges) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: exp v%0b s%0d u%h c%h got v%0b s%0d u%h c%h", results_seen,
                     e.violates, e.status, e.uncovered_edges, e.vertex_critical_edges,
                     out_data_o.violates, out_data_o.status, out_data_o.uncovered_edges,
                     out_data_o.vertex_critical_edges);
        end
      end
    end
  end

  // Long receiver hold, counted in cycles, while the sender keeps offering
  task automatic long_hold();
    hold_rx = 1'b1;
    repeat (400) @(negedge clk_i);
    hold_rx = 1'b0;
  endtask

  // One random search walk: load rows, clear, then add/check/remove along a stack plus noise items
  task automatic search_walk(int unsigned n_items);
    int unsigned lim, v, sp, lv;
    int unsigned stack_v [32];
    logic [31:0] s;
    logic [127:0] rnd;
    hscu_pkg::in_item_t it;
    lim = vtx_limit();
    for (int i = 0; i < lim; i++) begin
      if (!row_loaded[i] || $urandom_range(0, 3) == 0) begin
        send_beat(mk(hscu_pkg::KindLoad, i, $urandom, $urandom,
                     {$urandom, $urandom} & {$urandom, $urandom}));
        row_loaded[i] = 1'b1;
      end
    end
    send_beat(mk(hscu_pkg::KindClear, $urandom, $urandom, $urandom, {$urandom, $urandom}));
    sp = 0;
    s = '0;
    for (int i = 0; i < n_items; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          v = $urandom_range(0, lim - 1);
          send_beat(mk(hscu_pkg::KindCheck, v, s, $urandom, {$urandom, $urandom}));
        end
        3, 4, 5: begin
          v = $urandom_range(0, lim - 1);
          if (!s[v] && sp < hscu_pkg::MaxLevels) begin
            send_beat(mk(hscu_pkg::KindAdd, v, s, sp, {$urandom, $urandom}));
            if (expected_q.size() != 0 && expected_q[$].status == hscu_pkg::StatOk) begin
              stack_v[sp] = v;
              s[v] = 1'b1;
              sp++;
            end
          end
        end
        6, 7, 8: begin
          if (sp != 0) begin
            sp--;
            s[stack_v[sp]] = 1'b0;
            send_beat(mk(hscu_pkg::KindRemove, stack_v[sp], s, sp, {$urandom, $urandom}));
          end
        end
        default: begin
          // noise: random kind, vertex or set, within loaded rows
          rnd = {$urandom, $urandom, $urandom, $urandom};
          it = rnd[$bits(hscu_pkg::in_item_t)-1:0];
          if (it.kind == hscu_pkg::KindLoad) begin
            if (it.vertex < lim) row_loaded[it.vertex] = 1'b1;
          end else if (it.vertex < lim && !row_loaded[it.vertex]) it.vertex = 0;
          if (it.kind == hscu_pkg::KindClear) begin
            sp = 0;
            s = '0;
          end
          send_beat(it);
        end
      endcase
    end
  endtask

  typedef struct {
    hscu_pkg::in_item_t it;
    logic [1:0]         st;
    logic [63:0]        unc;
    bit                 typed;
  } dir_row_t;

  initial begin
    dir_row_t rows [$];
    foreach (row_mem[i]) row_mem[i] = '0;
    foreach (crit_mem[i]) crit_mem[i] = '0;
    foreach (ovl_mem[i]) ovl_mem[i] = '0;
    foreach (row_loaded[i]) row_loaded[i] = 1'b0;
    edge_cnt = 7'd64;
    vtx_cnt = 6'd32;
    uncov_set = '1;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table: extremes, every kind, bad-precondition status
    rows.push_back('{mk(hscu_pkg::KindLoad, 0, '1, 31, '1), hscu_pkg::StatOk, '1, 1'b1});
    rows.push_back('{mk(hscu_pkg::KindLoad, 31, 0, 0, 64'h8000_0000_0000_0001),
                     hscu_pkg::StatOk, '1, 1'b1});
    rows.push_back('{mk(hscu_pkg::KindLoad, 1, 0, 0, 64'h0F0F), hscu_pkg::StatOk, '1, 1'b1});
    rows.push_back('{mk(hscu_pkg::KindCheck, 1, 0, 0, 0), hscu_pkg::StatOk, '1, 1'b1});
    rows.push_back('{mk(hscu_pkg::KindAdd, 0, 0, 0, 0), hscu_pkg::StatOk, '0, 1'b1});
    rows.push_back('{mk(hscu_pkg::KindCheck, 1, 32'h1, 0, 0), hscu_pkg::StatOk, '0, 1'b0});
    rows.push_back('{mk(hscu_pkg::KindAdd, 0, 32'h1, 1, 0), hscu_pkg::StatBadPre, '0, 1'b1});
    rows.push_back('{mk(hscu_pkg::KindAdd, 1, 32'h0, 2, 0), hscu_pkg::StatOk, '0, 1'b1});
    rows.push_back('{mk(hscu_pkg::KindRemove, 0, 0, 0, 0), hscu_pkg::StatOk, '1, 1'b1});
    rows.push_back('{mk(hscu_pkg::KindRemove, 31, 0, 5, 0), hscu_pkg::StatOk, '1, 1'b1});
    rows.push_back('{mk(hscu_pkg::KindAdd, 31, 0, 31, 0), hscu_pkg::StatOk,
                     64'h7FFF_FFFF_FFFF_FFFE, 1'b1});
    rows.push_back('{mk(hscu_pkg::KindAdd, 1, 32'h8000_0000, 30, 0), hscu_pkg::StatOk,
                     '0, 1'b0});
    rows.push_back('{mk(hscu_pkg::KindCheck, 0, 32'h8000_0002, 3, 0), hscu_pkg::StatOk,
                     '0, 1'b0});
    rows.push_back('{mk(hscu_pkg::KindRemove, 1, 32'h8000_0000, 30, 0), hscu_pkg::StatOk,
                     '0, 1'b0});
    rows.push_back('{mk(hscu_pkg::kind_e'(3'd5), 0, 0, 0, 0), hscu_pkg::StatBadPre, '0, 1'b0});
    rows.push_back('{mk(hscu_pkg::kind_e'(3'd7), 31, '1, 31, '1), hscu_pkg::StatBadPre,
                     '0, 1'b0});
    rows.push_back('{mk(hscu_pkg::KindClear, 31, '1, 31, '1), hscu_pkg::StatOk, '1, 1'b1});
    foreach (rows[i]) begin
      if (rows[i].typed) send_known(rows[i].it, rows[i].st, rows[i].unc);
      else send_beat(rows[i].it);
    end
    row_loaded[0] = 1'b1;
    row_loaded[1] = 1'b1;
    row_loaded[31] = 1'b1;
    drain();

    // Out-of-range vertex and empty edge mask
    write_reg(hscu_pkg::CfgNumVertices, 7'd4);
    write_reg(hscu_pkg::CfgNumEdges, 7'd0);
    send_beat(mk(hscu_pkg::KindLoad, 4, 0, 0, '1));
    send_beat(mk(hscu_pkg::KindClear, 0, 0, 0, 0));
    send_beat(mk(hscu_pkg::KindAdd, 31, 0, 0, 0));
    drain();

    // Random phases over several register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(hscu_pkg::CfgNumEdges, 7'd64);
          write_reg(hscu_pkg::CfgNumVertices, 7'd32);
        end
        1: begin
          write_reg(hscu_pkg::CfgNumEdges, 7'd1);
          write_reg(hscu_pkg::CfgNumVertices, 7'd1);
        end
        2: begin
          write_reg(hscu_pkg::CfgNumEdges, 7'd127);
          write_reg(hscu_pkg::CfgNumVertices, 7'd63);
        end
        7: begin
          write_reg(hscu_pkg::CfgNumEdges, 7'd8);
          write_reg(hscu_pkg::CfgNumVertices, 7'd6);
        end
        default: begin
          write_reg(hscu_pkg::CfgNumEdges, 7'($urandom_range(1, 64)));
          write_reg(hscu_pkg::CfgNumVertices, 7'($urandom_range(2, 32)));
        end
      endcase
      if (ph == 3) fork long_hold(); join_none
      if (ph == 7) begin
        in_idle_en = 1'b0;
        out_idle_en = 1'b0;
      end
      search_walk(260);
      drain();
    end

    $display("covered directed table, 8 register settings and random add/check/remove walks");
    $display("%0d result beats checked, %0d with violates set", results_seen, violations_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("hitting_set_crit_uncov_engine: match");
    end else begin
      $display("hitting_set_crit_uncov_engine: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #60ms;
    $display("hitting_set_crit_uncov_engine: mismatch");
    $finish;
  end

endmodule
